// File: rtl/tfdb_pkg.sv
// ----------------------------------------------------------------------------
// tfdb_pkg
// Shared widths, constants and types of the timed frame delay buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfdb_pkg;

    localparam int DEPTH        = 1024;
    localparam int SLOT_BITS    = 10;
    localparam int DEPTH_BITS   = 11;
    localparam int COUNT_BITS   = 32;
    localparam int TIME_BITS    = 48;
    localparam int FRAME_BITS   = 32;
    localparam int DELAY_BITS   = 47;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 47;
    localparam int ENTRY_BITS   = 1 + TIME_BITS + FRAME_BITS;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_NS     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUFFER_DEPTH = 1'b1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 47'd1000000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 11'd1000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN   = 11'd2;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX   = 11'd1024;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [DELAY_BITS-1:0] delay_t;

    // one ring entry; pending is the inverse of the sent flag
    typedef struct packed {
        logic   pending;
        time_t  stamp;
        frame_t frame;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/tfdb_ram.sv
// ----------------------------------------------------------------------------
// tfdb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tfdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/tfdb_age_cmp.sv
// ----------------------------------------------------------------------------
// tfdb_age_cmp
// Age compare unit: decides whether a stored time is older than the delay.
// ----------------------------------------------------------------------------
`default_nettype none

module tfdb_age_cmp (
    input  wire tfdb_pkg::time_t  now,
    input  wire tfdb_pkg::time_t  stored,
    input  wire tfdb_pkg::delay_t delay,
    output logic                  old_enough
);

    tfdb_pkg::time_t age;

    // age wraps modulo the time width; upper half means a future stamp
    assign age        = now - stored;
    assign old_enough = !age[tfdb_pkg::TIME_BITS-1]
                        && (age[tfdb_pkg::DELAY_BITS-1:0] > delay);

endmodule

`default_nettype wire

// File: rtl/timed_frame_delay_buffer.sv
// ----------------------------------------------------------------------------
// timed_frame_delay_buffer
// Ring buffer that holds frame words and releases them once older than a delay.
// ----------------------------------------------------------------------------
// When an item's counter differs from the last one, its word and time go into
// the ring at the write pointer. The read pointer then walks over pending
// entries older than delay_ns, releasing each, and one result reports the last
// entry released and the next write slot. The ring lives in a single RAM
// holding pending flag, time and word per entry; one age compare unit checks
// one entry per visit. Each visit is one RAM read followed by one compare.
// After reset a clearing pass marks every entry sent before the first item is
// taken; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_frame_delay_buffer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // input items
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // frame_count [31:0], write_time_ns [79:32], frame_word [111:80]
    input  wire logic [111:0]  s_tdata,
    // results
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // frame_out [31:0], released_slot [41:32], write_slot [51:42], zero fill
    output logic [55:0]        m_tdata,
    // released [0]
    output logic               m_tuser,
    // configuration writes
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [tfdb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tfdb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef logic [tfdb_pkg::SLOT_BITS-1:0]  slot_t;
    typedef logic [tfdb_pkg::DEPTH_BITS-1:0] depth_t;

    function automatic depth_t eff_depth(input depth_t d);
        depth_t r;
        r = d;
        if (d < tfdb_pkg::DEPTH_MIN)
        begin
            r = tfdb_pkg::DEPTH_MIN;
        end
        else if (d > tfdb_pkg::DEPTH_MAX)
        begin
            r = tfdb_pkg::DEPTH_MAX;
        end
        return r;
    endfunction

    function automatic slot_t advance(input slot_t p, input depth_t depth);
        depth_t n;
        n = {1'b0, p} + depth_t'(1);
        return (n >= depth) ? slot_t'(0) : n[tfdb_pkg::SLOT_BITS-1:0];
    endfunction

    state_t state_reg, state_next;

    tfdb_pkg::delay_t delay_reg;
    depth_t           depth_reg;
    depth_t           depth_eff;

    logic [tfdb_pkg::COUNT_BITS-1:0] last_count_reg;
    slot_t write_ptr_reg, write_ptr_next;
    slot_t read_ptr_reg, read_ptr_next;
    slot_t clr_cnt_reg;

    logic [tfdb_pkg::COUNT_BITS-1:0] count_in;
    tfdb_pkg::time_t                 now_reg;
    tfdb_pkg::frame_t                word_reg;
    logic                            new_frame_reg;

    logic             rel_reg, rel_next;
    slot_t            last_slot_reg, last_slot_next;
    tfdb_pkg::frame_t last_frame_reg, last_frame_next;

    logic             out_valid_reg;
    logic             out_rel_reg;
    tfdb_pkg::frame_t out_frame_reg;
    slot_t            out_rslot_reg;
    slot_t            out_wslot_reg;

    logic                    ram_we;
    slot_t                   ram_waddr;
    tfdb_pkg::entry_t        ram_wentry;
    logic [tfdb_pkg::ENTRY_BITS-1:0] ram_rdata;
    tfdb_pkg::entry_t        rd_entry;
    logic                    old_enough;
    logic                    release_now;
    logic                    accept;
    logic                    out_free;

    assign count_in  = s_tdata[31:0];
    assign depth_eff = eff_depth(depth_reg);
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_entry  = tfdb_pkg::entry_t'(ram_rdata);

    tfdb_ram #(
        .WIDTH (tfdb_pkg::ENTRY_BITS),
        .DEPTH (tfdb_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (read_ptr_reg),
        .rdata (ram_rdata)
    );

    tfdb_age_cmp u_age (
        .now        (now_reg),
        .stored     (rd_entry.stamp),
        .delay      (delay_reg),
        .old_enough (old_enough)
    );

    assign release_now = (state_reg == ST_CHECK) && rd_entry.pending && old_enough;

    // ring write port
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = read_ptr_reg;
        ram_wentry = rd_entry;
        ram_wentry.pending = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clr_cnt_reg;
                ram_wentry = '0;
            end
            ST_WRITE:
            begin
                ram_we             = 1'b1;
                ram_waddr          = write_ptr_reg;
                ram_wentry.pending = 1'b1;
                ram_wentry.stamp   = now_reg;
                ram_wentry.frame   = word_reg;
            end
            ST_CHECK:
            begin
                ram_we = release_now;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        write_ptr_next  = write_ptr_reg;
        read_ptr_next   = read_ptr_reg;
        rel_next        = rel_reg;
        last_slot_next  = last_slot_reg;
        last_frame_next = last_frame_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == slot_t'(tfdb_pkg::DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rel_next        = 1'b0;
                    last_slot_next  = '0;
                    last_frame_next = '0;
                    state_next      = (count_in != last_count_reg) ? ST_WRITE : ST_READ;
                end
            end
            ST_WRITE:
            begin
                write_ptr_next = advance(write_ptr_reg, depth_eff);
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (release_now)
                begin
                    rel_next        = 1'b1;
                    last_slot_next  = read_ptr_reg;
                    last_frame_next = rd_entry.frame;
                    read_ptr_next   = advance(read_ptr_reg, depth_eff);
                    state_next      = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            delay_reg      <= tfdb_pkg::DELAY_RESET;
            depth_reg      <= tfdb_pkg::DEPTH_RESET;
            last_count_reg <= '0;
            write_ptr_reg  <= '0;
            read_ptr_reg   <= '0;
            rel_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            rel_reg       <= rel_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + slot_t'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tfdb_pkg::CFG_DELAY_NS:
                    begin
                        delay_reg <= cfg_data[tfdb_pkg::DELAY_BITS-1:0];
                    end
                    tfdb_pkg::CFG_BUFFER_DEPTH:
                    begin
                        depth_reg <= cfg_data[tfdb_pkg::DEPTH_BITS-1:0];
                    end
                    default:
                    begin
                        delay_reg <= delay_reg;
                    end
                endcase
            end
            if (accept && (count_in != last_count_reg))
            begin
                last_count_reg <= count_in;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_slot_reg  <= last_slot_next;
        last_frame_reg <= last_frame_next;
        if (accept)
        begin
            now_reg       <= s_tdata[79:32];
            word_reg      <= s_tdata[111:80];
            new_frame_reg <= (count_in != last_count_reg);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_rel_reg   <= rel_reg;
            out_frame_reg <= last_frame_reg;
            out_rslot_reg <= last_slot_reg;
            out_wslot_reg <= write_ptr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rel_reg;
    assign m_tdata  = {4'b0000, out_wslot_reg, out_rslot_reg, out_frame_reg};

`ifndef SYNTHESIS
    a_write_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> new_frame_reg)
        else $error("ring written for a repeated frame counter");

    a_release_needs_age: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && ram_we) |-> (rd_entry.pending && old_enough))
        else $error("entry released while not pending or too young");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("next item taken before the current one finished");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done step");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rel_reg) |-> (out_rslot_reg == '0 && out_frame_reg == '0))
        else $error("no release but slot or frame nonzero");
`endif

endmodule

`default_nettype wire

// File: test/timed_frame_delay_buffer_checker.sv
// ----------------------------------------------------------------------------
// timed_frame_delay_buffer_checker
// Watches the item, result and register channels of the frame delay buffer,
// keeps its own copy of the ring and the registers, and compares every
// result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------

module timed_frame_delay_buffer_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    // frame_count [31:0], write_time_ns [79:32], frame_word [111:80]
    input  wire logic [111:0]              s_tdata,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    // frame_out [31:0], released_slot [41:32], write_slot [51:42], zero fill
    input  wire logic [55:0]               m_tdata,
    // released [0]
    input  wire logic                      m_tuser,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [tfdb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tfdb_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                             errors,
    output int                             awaiting,
    output int                             results,
    output int                             releases
);
    timeunit 1ns;
    timeprecision 1ps;

    import tfdb_pkg::*;

    typedef struct packed {
        logic                 released;
        frame_t               frame;
        logic [SLOT_BITS-1:0] slot;
        logic [SLOT_BITS-1:0] wr_slot;
    } release_report_t;

    // model of the ring and the registers
    delay_t                 delay_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [COUNT_BITS-1:0]  last_seen;
    logic [SLOT_BITS-1:0]   wr_slot;
    logic [SLOT_BITS-1:0]   rd_slot;
    logic                   pending_flag [DEPTH];
    time_t                  stamp_mem [DEPTH];
    frame_t                 word_mem [DEPTH];

    release_report_t        due_results [$];

    function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] p,
                                                       input int span);
        int n;
        n = int'(p) + 1;
        return (n >= span) ? '0 : n[SLOT_BITS-1:0];
    endfunction

    // age is taken modulo the time width; the upper half counts as future
    function automatic logic is_due(input time_t stamp, input time_t now);
        time_t age;
        age = now - stamp;
        return !age[TIME_BITS-1] && (age > {1'b0, delay_reg});
    endfunction

    task automatic store_and_walk(input logic [COUNT_BITS-1:0] count, input time_t now,
                                  input frame_t word);
        release_report_t r;
        int span;
        int n;
        if (depth_reg < DEPTH_MIN)
            span = int'(DEPTH_MIN);
        else if (depth_reg > DEPTH_MAX)
            span = DEPTH;
        else
            span = int'(depth_reg);
        if (count != last_seen)
        begin
            last_seen = count;
            stamp_mem[wr_slot] = now;
            word_mem[wr_slot] = word;
            pending_flag[wr_slot] = 1'b1;
            wr_slot = next_slot(wr_slot, span);
        end
        r = '0;
        for (n = 0; n < DEPTH && pending_flag[rd_slot] && is_due(stamp_mem[rd_slot], now); n++)
        begin
            pending_flag[rd_slot] = 1'b0;
            r.released = 1'b1;
            r.slot = rd_slot;
            rd_slot = next_slot(rd_slot, span);
        end
        if (r.released)
            r.frame = word_mem[r.slot];
        r.wr_slot = wr_slot;
        due_results.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        $display("[%0t] result %0d: %s is %0h, expected %0h", $time, results, what, got,
                 want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        release_report_t want;
        int i;
        if (!rst_n)
        begin
            delay_reg = DELAY_RESET;
            depth_reg = DEPTH_RESET;
            last_seen = '0;
            wr_slot = '0;
            rd_slot = '0;
            for (i = 0; i < DEPTH; i++)
            begin
                pending_flag[i] = 1'b0;
                stamp_mem[i] = '0;
                word_mem[i] = '0;
            end
            due_results.delete();
            errors = 0;
            awaiting = 0;
            results = 0;
            releases = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DELAY_NS)
                    delay_reg = cfg_data[DELAY_BITS-1:0];
                else if (cfg_index == CFG_BUFFER_DEPTH)
                    depth_reg = cfg_data[DEPTH_BITS-1:0];
            end
            // results are matched before this edge's item is predicted
            if (m_tvalid && m_tready)
            begin
                results++;
                if (due_results.size() == 0)
                    flag_mismatch("result with nothing expected, data", 64'(m_tdata),
                                  64'd0);
                else
                begin
                    want = due_results.pop_front();
                    if (want.released)
                        releases++;
                    if (m_tuser !== want.released)
                        flag_mismatch("released", 64'(m_tuser), 64'(want.released));
                    if (m_tdata[31:0] !== want.frame)
                        flag_mismatch("frame_out", 64'(m_tdata[31:0]), 64'(want.frame));
                    if (m_tdata[41:32] !== want.slot)
                        flag_mismatch("released_slot", 64'(m_tdata[41:32]), 64'(want.slot));
                    if (m_tdata[51:42] !== want.wr_slot)
                        flag_mismatch("write_slot", 64'(m_tdata[51:42]), 64'(want.wr_slot));
                    if (m_tdata[55:52] !== 4'd0)
                        flag_mismatch("fill bits", 64'(m_tdata[55:52]), 64'd0);
                end
            end
            if (s_tvalid && s_tready)
                store_and_walk(s_tdata[31:0], s_tdata[79:32], s_tdata[111:80]);
            awaiting = due_results.size();
        end
    end

endmodule

// File: test/timed_frame_delay_buffer_test.sv
// ----------------------------------------------------------------------------
// timed_frame_delay_buffer_test
// Drives frames and register writes into the frame delay buffer, with random
// sender gaps and receiver stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------

module timed_frame_delay_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfdb_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 12;
    localparam int     RANDOM_ITEMS  = 1600;
    localparam int     FILL_ITEMS    = 300;
    // longest walk covers the whole ring, each entry a read and a compare
    localparam int     SETTLE_CYCLES = 2 * DEPTH + 16;
    // limit for the whole run, clearing pass included
    localparam int     CYCLE_LIMIT   = 500000;
    localparam delay_t DELAY_TOP     = '1;
    localparam time_t  TIME_TOP      = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_SQUARE, RX_SPARSE, RX_RARE} stall_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [111:0]              s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [55:0]               m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int                        errors;
    int                        awaiting;
    int                        results;
    int                        releases;

    int                        items_sent = 0;
    int                        cfg_writes = 0;
    int                        burst_left = 0;
    bit                        gaps_on = 1'b0;
    delay_t                    delay_now = DELAY_RESET;
    int unsigned               rx_cycle = 0;
    stall_t                    rx_mode = RX_OPEN;
    int unsigned               cycle_count = 0;

    timed_frame_delay_buffer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    timed_frame_delay_buffer_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .awaiting  (awaiting),
        .results   (results),
        .releases  (releases)
    );

    always
    begin
        clk = 1'b1;
        #(CLK_HALF);
        clk = 1'b0;
        #(CLK_HALF);
    end

    // receiver stall pattern, redrawn at random from five modes
    always @(negedge clk)
    begin
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 200 == 0)
            rx_mode = stall_t'($urandom_range(0, 4));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SQUARE: m_tready <= rx_cycle[2];
            RX_SPARSE: m_tready <= (rx_cycle[2:0] == 3'd0);
            default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, awaiting);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one item transfer; valid stays high into the next call unless a gap falls
    task automatic send_frame(input logic [COUNT_BITS-1:0] count, input time_t stamp,
                              input frame_t word);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {word, stamp, count};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
    endtask

    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DELAY_NS)
            delay_now = value[DELAY_BITS-1:0];
        cfg_writes++;
    endtask

    initial
    begin : stimulus
        logic [COUNT_BITS-1:0]    frame_no;
        time_t                    now_ns;
        logic [63:0]              wide;
        logic [63:0]              unit;
        delay_t                   delay_val;
        logic [DEPTH_BITS-1:0]    depth_val;
        int                       directed_items;
        int                       phase;
        int                       burst_items;
        int                       n;
        int                       pick;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: counter zero is not a new frame
        send_frame(32'd0, 48'd0, 32'd0);
        send_frame(32'd1, 48'd100, 32'hFFFF_FFFF);
        // age equal to the delay holds, one more ns releases
        send_frame(32'd1, 48'd1_000_100, 32'h0000_1234);
        send_frame(32'd1, 48'd1_000_101, 32'd0);
        send_frame(32'hFFFF_FFFF, TIME_TOP, 32'd0);
        // time wraps through zero
        send_frame(32'd0, 48'd1_000_000, 32'hA5A5_5A5A);
        // stamp ahead of now and age of exactly half the range count as future
        send_frame(32'd2, 48'd999_990, 32'h5A5A_A5A5);
        send_frame(32'd3, 48'h8000_000F_4240, 32'h8000_0001);
        send_frame(32'd3, 48'h8000_000F_423F, 32'h7FFF_FFFE);
        set_reg(CFG_DELAY_NS, DELAY_TOP);
        send_frame(32'd4, 48'h7FFF_FFFF_FFFF, 32'hDEAD_BEEF);
        send_frame(32'd5, 48'h0000_0000_0001, 32'h0BAD_F00D);
        // shrinking the ring leaves both pointers past its end
        set_reg(CFG_BUFFER_DEPTH, 47'd0);
        send_frame(32'd6, 48'd2_000_000, 32'h1111_1111);
        send_frame(32'd7, 48'd2_000_000, 32'h2222_2222);
        set_reg(CFG_DELAY_NS, 47'd0);
        send_frame(32'd7, 48'd2_000_000, 32'h3333_3333);
        send_frame(32'd7, 48'd2_000_001, 32'h4444_4444);
        set_reg(CFG_BUFFER_DEPTH, 47'd1);
        send_frame(32'd8, 48'd2_000_005, 32'h5555_5555);
        send_frame(32'd9, 48'd2_000_009, 32'h6666_6666);
        set_reg(CFG_BUFFER_DEPTH, 47'd2047);
        send_frame(32'd10, 48'd2_000_010, 32'h7777_7777);
        send_frame(32'd11, 48'd2_000_012, 32'h8888_8888);
        // only the low eleven bits of a depth write count
        set_reg(CFG_BUFFER_DEPTH, 47'h7FFF_FFFF_F803);
        send_frame(32'd12, 48'd2_000_020, 32'h9999_9999);
        send_frame(32'd13, 48'd2_000_030, 32'hAAAA_AAAA);
        send_frame(32'd14, 48'd2_000_031, 32'hBBBB_BBBB);
        directed_items = items_sent;

        frame_no = 32'd100;
        now_ns = 48'd3_000_000;
        phase = 0;
        while (items_sent - directed_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            if (phase == 2)
            begin
                // hold a long run of frames, then let one item release them all
                set_reg(CFG_DELAY_NS, DELAY_TOP);
                set_reg(CFG_BUFFER_DEPTH, 47'd2047);
                for (n = 0; n < FILL_ITEMS; n++)
                begin
                    now_ns = now_ns + time_t'($urandom_range(1, 1000));
                    frame_no = frame_no + 1;
                    send_frame(frame_no, now_ns, $urandom);
                end
                set_reg(CFG_DELAY_NS, 47'd0);
                now_ns = now_ns + 48'd1;
                send_frame(frame_no, now_ns, $urandom);
            end

            pick = $urandom_range(0, 7);
            case (pick)
                0: delay_val = '0;
                1: delay_val = delay_t'(1);
                2: delay_val = delay_t'($urandom_range(2, 5000));
                3: delay_val = DELAY_RESET;
                4: delay_val = delay_t'($urandom_range(0, 32'h8000_0000));
                5:
                begin
                    wide = {$urandom, $urandom};
                    delay_val = wide[DELAY_BITS-1:0];
                end
                6: delay_val = DELAY_TOP;
                default: delay_val = delay_t'($urandom_range(1000, 100000));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0: depth_val = 11'd0;
                1: depth_val = 11'd1;
                2: depth_val = 11'd2;
                3: depth_val = 11'd3;
                4: depth_val = 11'($urandom_range(4, 16));
                5: depth_val = 11'($urandom_range(2, 1024));
                6: depth_val = DEPTH_RESET;
                7: depth_val = DEPTH_MAX;
                8: depth_val = 11'd2047;
                default: depth_val = 11'($urandom_range(0, 2047));
            endcase
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                set_reg(CFG_BUFFER_DEPTH, {36'd0, depth_val});
                set_reg(CFG_DELAY_NS, delay_val);
            end
            else if (pick == 1)
                set_reg(CFG_DELAY_NS, delay_val);
            else
            begin
                set_reg(CFG_DELAY_NS, delay_val);
                set_reg(CFG_BUFFER_DEPTH, {36'd0, depth_val});
            end

            if ($urandom_range(0, 3) == 0)
                frame_no = $urandom;
            if ($urandom_range(0, 3) == 0)
            begin
                wide = {$urandom, $urandom};
                now_ns = wide[TIME_BITS-1:0];
            end

            // time steps scale with the delay so releases come every few items
            unit = ({17'd0, delay_now} >> 2) + 64'd1;
            burst_items = $urandom_range(20, 120);
            for (n = 0; n < burst_items; n++)
            begin
                if (phase == 4 && n == burst_items / 2)
                    wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    wide = {$urandom, $urandom};
                    send_frame($urandom, wide[TIME_BITS-1:0], $urandom);
                end
                else
                begin
                    now_ns = now_ns + time_t'(unit * $urandom_range(0, 6) +
                                              $urandom_range(0, 2));
                    if (pick >= 20)
                        frame_no = frame_no + 1;
                    send_frame(frame_no, now_ns, $urandom);
                end
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("drove %0d frame items (%0d directed) over %0d setting phases, %0d register writes",
                 items_sent, directed_items, phase, cfg_writes);
        $display("checked %0d results, %0d releasing a frame, %0d mismatches, %0d left due",
                 results, releases, errors, awaiting);
        if (errors == 0 && awaiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
